// File: src/mtg_pkg.sv
// Shared constants, types and the tempering function of the Mersenne Twister generator.
`timescale 1ns / 1ps
`default_nettype none

package mtg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_SHIFT  = 397;
    localparam int WORD_W       = 32;
    localparam int ADDR_W       = $clog2(STATE_WORDS + 1);

    localparam logic [WORD_W-1:0] TWIST_MAGIC  = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] INIT_MULT    = 32'h6c07_8965;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd342;
    localparam logic [WORD_W-1:0] UPPER_BIT    = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWER_BITS   = 32'h7fff_ffff;

    localparam logic [1:0] ACT_SEED_ONE = 2'd0;
    localparam logic [1:0] ACT_SEED_TWO = 2'd1;
    localparam logic [1:0] ACT_DRAW     = 2'd2;
    localparam logic [1:0] ACT_BOUNDED  = 2'd3;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [WORD_W-1:0] t_word;

    // Commands from the sequencer to the seed extension unit.
    typedef struct packed {
        logic  start;
        t_word start_word;
        t_addr start_idx;
        logic  mul;
        logic  add;
    } t_fill_ctl;

    function automatic t_word temper(input t_word x);
        t_word y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

// File: src/mtg_if.sv
// Request and response channel interfaces of the Mersenne Twister generator.
`timescale 1ns / 1ps
`default_nettype none

interface mtg_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] seed_low;
    logic [31:0] seed_high;
    logic [31:0] upper_bound;

    modport source (output valid, action, seed_low, seed_high, upper_bound, input ready);
    modport sink   (input valid, action, seed_low, seed_high, upper_bound, output ready);
endinterface

interface mtg_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] number;

    modport source (output valid, number, input ready);
    modport sink   (input valid, number, output ready);
endinterface

`default_nettype wire

// File: src/mtg_fill.sv
// Seed extension unit: one shared multiplier steps the initialization recurrence word by word.
`timescale 1ns / 1ps
`default_nettype none

module mtg_fill import mtg_pkg::*; (
    input  logic      i_clk,
    input  t_fill_ctl i_ctl,
    output logic      o_wr_en,
    output t_addr     o_wr_addr,
    output t_word     o_wr_data,
    output logic      o_last
);

    t_word r_w;
    t_word r_prod;
    t_addr r_idx;
    t_word n_w;

    assign n_w       = r_prod + {{(WORD_W-ADDR_W){1'b0}}, r_idx};
    assign o_wr_en   = i_ctl.add;
    assign o_wr_addr = r_idx;
    assign o_wr_data = n_w;
    assign o_last    = (r_idx == t_addr'(STATE_WORDS - 1));

    // The product is registered; the index is added in the following cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_w   <= i_ctl.start_word;
            r_idx <= i_ctl.start_idx;
        end else if (i_ctl.add) begin
            r_w   <= n_w;
            r_idx <= r_idx + t_addr'(1);
        end
        if (i_ctl.mul) begin
            r_prod <= INIT_MULT * (r_w ^ (r_w >> 30));
        end
    end

endmodule

`default_nettype wire

// File: src/mersenne_twister_generator.sv
// Top level of the MT19937 generator: state memory, draw sequencer and result register.
//
//  channel | dir | payload                                   | handshake
//  i_req   | in  | action, seed_low, seed_high, upper_bound  | valid / ready
//  o_rsp   | out | number                                    | valid / ready
//
// A draw runs the read, twist and output states, then registers its result; a first
// draw after a seed also loads the current word, and a rejected bounded value reads anew.
// Each word is twisted when it is read, using the two read ports of the state memory.
// A seed fills the state word by word, alternating the multiply and add states;
// a draw before any seed first runs the default seed.
// Reset is synchronous; the memory is not cleared. A stalled result holds in the
// output register and the block takes the next request meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module mersenne_twister_generator import mtg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mtg_req_if.sink   i_req,
    mtg_rsp_if.source o_rsp
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SEED_HI  = 4'd1;
    localparam logic [3:0] S_FILL_MUL = 4'd2;
    localparam logic [3:0] S_FILL_ADD = 4'd3;
    localparam logic [3:0] S_DRAW_RD  = 4'd4;
    localparam logic [3:0] S_DRAW_CUR = 4'd5;
    localparam logic [3:0] S_DRAW_TW  = 4'd6;
    localparam logic [3:0] S_DRAW_OUT = 4'd7;
    localparam logic [3:0] S_EMIT     = 4'd8;

    localparam t_addr LAST_ADDR = t_addr'(STATE_WORDS - 1);

    t_word mem [STATE_WORDS];

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_addr      r_pos;
    logic       r_has_seed;
    logic       r_cur_ok;
    logic       r_pend;
    logic       r_bounded;
    t_word      r_bound;
    t_word      r_mask;
    t_word      r_seed_high;
    t_word      r_cur;
    t_word      r_tw;
    t_word      r_res;
    t_word      r_rd_a;
    t_word      r_rd_b;
    logic       r_out_valid;
    t_word      r_out_num;

    logic        accept;
    logic        out_free;
    t_addr       p_eff;
    t_addr       p_next;
    t_addr       p_far;
    logic [ADDR_W:0] far_sum;
    t_word       twist_y;
    t_word       twist_v;
    t_word       drawn;
    t_word       smear;
    logic        wr_en;
    t_addr       wr_addr;
    t_word       wr_data;
    logic        rd_en;
    t_addr       rd_addr_a;
    t_fill_ctl   fill_ctl;
    logic        fill_wr_en;
    t_addr       fill_wr_addr;
    t_word       fill_wr_data;
    logic        fill_last;

    assign i_req.ready  = (r_state == S_IDLE);
    assign accept       = i_req.valid && (r_state == S_IDLE);
    assign out_free     = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.number = r_out_num;

    // A read position past the end means the next word is the first of a new batch.
    assign p_eff   = (r_pos == t_addr'(STATE_WORDS)) ? '0 : r_pos;
    assign p_next  = (p_eff == LAST_ADDR) ? '0 : p_eff + t_addr'(1);
    assign far_sum = {1'b0, p_eff} + (ADDR_W+1)'(TWIST_SHIFT);
    assign p_far   = (far_sum >= (ADDR_W+1)'(STATE_WORDS))
                     ? ADDR_W'(far_sum - (ADDR_W+1)'(STATE_WORDS)) : far_sum[ADDR_W-1:0];

    assign twist_y = (r_cur & UPPER_BIT) | (r_rd_a & LOWER_BITS);
    assign twist_v = r_rd_b ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MAGIC : '0);
    assign drawn   = temper(r_tw) & r_mask;

    always_comb begin
        smear = i_req.upper_bound;
        for (int k = 1; k < WORD_W; k = k * 2) begin
            smear = smear | (smear >> k);
        end
    end

    mtg_fill u_fill (
        .i_clk     (i_clk),
        .i_ctl     (fill_ctl),
        .o_wr_en   (fill_wr_en),
        .o_wr_addr (fill_wr_addr),
        .o_wr_data (fill_wr_data),
        .o_last    (fill_last)
    );

    always_comb begin
        n_state             = r_state;
        fill_ctl            = '0;
        fill_ctl.start_word = i_req.seed_low;
        fill_ctl.start_idx  = t_addr'(1);
        wr_en               = 1'b0;
        wr_addr             = '0;
        wr_data             = i_req.seed_low;
        rd_en               = 1'b0;
        rd_addr_a           = p_next;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.action) inside
                        ACT_SEED_ONE: begin
                            wr_en          = 1'b1;
                            fill_ctl.start = 1'b1;
                            n_state        = S_FILL_MUL;
                        end
                        ACT_SEED_TWO: begin
                            wr_en   = 1'b1;
                            n_state = S_SEED_HI;
                        end
                        ACT_DRAW, ACT_BOUNDED: begin
                            if (r_has_seed) begin
                                n_state = S_DRAW_RD;
                            end else begin
                                wr_en               = 1'b1;
                                wr_data             = DEFAULT_SEED;
                                fill_ctl.start      = 1'b1;
                                fill_ctl.start_word = DEFAULT_SEED;
                                n_state             = S_FILL_MUL;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SEED_HI: begin
                wr_en               = 1'b1;
                wr_addr             = t_addr'(1);
                wr_data             = r_seed_high;
                fill_ctl.start      = 1'b1;
                fill_ctl.start_word = r_seed_high;
                fill_ctl.start_idx  = t_addr'(2);
                n_state             = S_FILL_MUL;
            end
            S_FILL_MUL: begin
                fill_ctl.mul = 1'b1;
                n_state      = S_FILL_ADD;
            end
            S_FILL_ADD: begin
                fill_ctl.add = 1'b1;
                wr_en        = fill_wr_en;
                wr_addr      = fill_wr_addr;
                wr_data      = fill_wr_data;
                if (fill_last) begin
                    n_state = r_pend ? S_DRAW_RD : S_EMIT;
                end else begin
                    n_state = S_FILL_MUL;
                end
            end
            S_DRAW_RD: begin
                rd_en     = 1'b1;
                rd_addr_a = r_cur_ok ? p_next : p_eff;
                n_state   = r_cur_ok ? S_DRAW_TW : S_DRAW_CUR;
            end
            S_DRAW_CUR: begin
                n_state = S_DRAW_RD;
            end
            S_DRAW_TW: begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
                wr_data = twist_v;
                n_state = S_DRAW_OUT;
            end
            S_DRAW_OUT: begin
                n_state = (r_bounded && (drawn > r_bound)) ? S_DRAW_RD : S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State memory: one write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= mem[rd_addr_a];
            r_rd_b <= mem[p_far];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= t_addr'(STATE_WORDS);
            r_has_seed  <= 1'b0;
            r_cur_ok    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_pend <= (i_req.action == ACT_DRAW) || (i_req.action == ACT_BOUNDED);
            end
            if ((r_state == S_FILL_ADD) && fill_last) begin
                r_has_seed <= 1'b1;
                r_pos      <= t_addr'(STATE_WORDS);
                r_cur_ok   <= 1'b0;
            end
            if (r_state == S_DRAW_RD) begin
                r_pos <= p_eff;
            end
            if (r_state == S_DRAW_CUR) begin
                r_cur_ok <= 1'b1;
            end
            if (r_state == S_DRAW_TW) begin
                r_pos <= r_pos + t_addr'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bounded   <= (i_req.action == ACT_BOUNDED);
            r_bound     <= i_req.upper_bound;
            r_mask      <= (i_req.action == ACT_BOUNDED) ? smear : '1;
            r_seed_high <= i_req.seed_high;
            r_res       <= '0;
        end
        if (r_state == S_DRAW_CUR) begin
            r_cur <= r_rd_a;
        end
        // The word after this one is already read, so it becomes the next current word.
        if (r_state == S_DRAW_TW) begin
            r_tw  <= twist_v;
            r_cur <= r_rd_a;
        end
        if (r_state == S_DRAW_OUT) begin
            r_res <= drawn;
        end
        if ((r_state == S_EMIT) && out_free) begin
            r_out_num <= r_res;
        end
    end

endmodule

`default_nettype wire

// File: src/mtg_checker.sv
// Port-level checks of the Mersenne Twister generator and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mtg_checker import mtg_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic [1:0]  i_req_action,
    input logic [31:0] i_req_upper_bound,
    input logic        o_rsp_valid,
    input logic        o_rsp_ready,
    input logic [31:0] o_rsp_number
);

    logic        r_last_seed;
    logic        r_last_bounded;
    logic [31:0] r_last_bound;
    logic        in_xfer;
    logic        r_fresh_out;

    assign in_xfer = i_req_valid && i_req_ready;

    // The first cycle a result is shown always belongs to the latest request transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seed    <= 1'b0;
            r_last_bounded <= 1'b0;
            r_last_bound   <= '0;
            r_fresh_out    <= 1'b0;
        end else begin
            r_fresh_out <= 1'b1;
            if (in_xfer) begin
                r_last_seed    <= (i_req_action == ACT_SEED_ONE) ||
                                  (i_req_action == ACT_SEED_TWO);
                r_last_bounded <= (i_req_action == ACT_BOUNDED);
                r_last_bound   <= i_req_upper_bound;
            end
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_rsp_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid && $stable(o_rsp_number))
        else $error("stalled result changed");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_req_ready)
        else $error("request taken twice in a row");

    a_seed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh_out && o_rsp_valid && !$past(o_rsp_valid) && r_last_seed
        |-> o_rsp_number == '0)
        else $error("seed result not zero");

    a_bound_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh_out && o_rsp_valid && !$past(o_rsp_valid) && r_last_bounded
        |-> o_rsp_number <= r_last_bound)
        else $error("bounded result above bound");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_req_action      (i_req.action),
    .i_req_upper_bound (i_req.upper_bound),
    .o_rsp_valid       (o_rsp.valid),
    .o_rsp_ready       (o_rsp.ready),
    .o_rsp_number      (o_rsp.number)
);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench of the MT19937 generator: random requests, predicted numbers.
`timescale 1ns / 1ps

module testbench;
    import mtg_pkg::*;

    localparam int QUIET_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_RUN_WORDS = 660;

    // Keeps its own copy of the twister state and queues the number each request should return.
    class mt_number_checker;
        t_word twister[STATE_WORDS];
        int    read_pos;
        bit    seeded;
        int    drawn_since_seed;
        t_word expected_numbers[$];
        int    errors;

        function new();
            read_pos = STATE_WORDS;
            seeded = 1'b0;
            drawn_since_seed = 0;
            errors = 0;
        endfunction

        function void extend_from(int first);
            t_word w;
            for (int i = first; i < STATE_WORDS; i++) begin
                w = twister[i-1];
                twister[i] = INIT_MULT * (w ^ (w >> 30)) + t_word'(i);
            end
            read_pos = STATE_WORDS;
            seeded = 1'b1;
            drawn_since_seed = 0;
        endfunction

        function void twist_batch();
            t_word nxt, y, v;
            for (int i = 0; i < STATE_WORDS; i++) begin
                nxt = twister[(i + 1) % STATE_WORDS];
                y = (twister[i] & UPPER_BIT) | (nxt & LOWER_BITS);
                v = twister[(i + TWIST_SHIFT) % STATE_WORDS] ^ (y >> 1);
                if (y[0]) begin
                    v = v ^ TWIST_MAGIC;
                end
                twister[i] = v;
            end
            read_pos = 0;
        endfunction

        function t_word next_tempered();
            t_word y;
            if (!seeded) begin
                twister[0] = DEFAULT_SEED;
                extend_from(1);
            end
            if (read_pos >= STATE_WORDS) begin
                twist_batch();
            end
            y = twister[read_pos];
            read_pos++;
            drawn_since_seed++;
            y = y ^ (y >> 11);
            y = y ^ ((y << 7) & TEMPER_B);
            y = y ^ ((y << 15) & TEMPER_C);
            y = y ^ (y >> 18);
            return y;
        endfunction

        function void note_request(logic [1:0] act, t_word lo, t_word hi, t_word bnd);
            t_word mask;
            t_word num;
            num = '0;
            case (act)
                ACT_SEED_ONE: begin
                    twister[0] = lo;
                    extend_from(1);
                end
                ACT_SEED_TWO: begin
                    twister[0] = lo;
                    twister[1] = hi;
                    extend_from(2);
                end
                ACT_DRAW: begin
                    num = next_tempered();
                end
                ACT_BOUNDED: begin
                    mask = bnd;
                    mask = mask | (mask >> 1);
                    mask = mask | (mask >> 2);
                    mask = mask | (mask >> 4);
                    mask = mask | (mask >> 8);
                    mask = mask | (mask >> 16);
                    // Masked words above the bound are thrown away and drawing goes on.
                    do begin
                        num = next_tempered() & mask;
                    end while (num > bnd);
                end
            endcase
            expected_numbers.push_back(num);
        endfunction

        function void check_number(t_word got);
            t_word want;
            if (expected_numbers.size() == 0) begin
                $display("%0t: number with nothing expected: expected none, actual %h",
                         $time, got);
                errors++;
            end else begin
                want = expected_numbers.pop_front();
                if (got !== want) begin
                    $display("%0t: number mismatch: expected %h, actual %h", $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mtg_req_if req_ch();
    mtg_rsp_if rsp_ch();

    mersenne_twister_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    mt_number_checker predicted = new();

    bit no_idle = 1'b0;
    int idle_pct = 30;
    int results_seen = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Ends the run when neither channel has moved a transfer for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("** mersenne_twister_generator: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [1:0] act, input t_word lo, input t_word hi,
                             input t_word bnd);
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.seed_low    <= lo;
        req_ch.seed_high   <= hi;
        req_ch.upper_bound <= bnd;
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        predicted.note_request(act, lo, hi, bnd);
        @(negedge i_clk);
    endtask

    task automatic pace_sender();
        if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (predicted.expected_numbers.size() != 0);
    endtask

    task automatic random_item(input bit allow_seed);
        int pick;
        logic [1:0] act;
        t_word bnd;
        pick = $urandom_range(0, 99);
        if (allow_seed && pick < 5) begin
            act = ACT_SEED_ONE;
        end else if (allow_seed && pick < 10) begin
            act = ACT_SEED_TWO;
        end else if (pick < 35) begin
            act = ACT_DRAW;
        end else begin
            act = ACT_BOUNDED;
        end
        // Power-of-two bounds reject almost half of all masked words.
        case ($urandom_range(0, 3))
            0, 1: bnd = 32'h1 << $urandom_range(0, 31);
            2: bnd = $urandom >> $urandom_range(0, 31);
            default: bnd = $urandom;
        endcase
        pace_sender();
        send_item(act, $urandom, $urandom, bnd);
    endtask

    initial begin : response_side
        int stall_left;
        bit hold_done;
        bit calm;
        int cycle_count;
        stall_left = 0;
        hold_done = 1'b0;
        calm = 1'b0;
        cycle_count = 0;
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            cycle_count++;
            if (cycle_count % 64 == 0) begin
                calm = ($urandom_range(0, 2) == 0);
            end
            if (!hold_done && results_seen >= 150) begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !no_idle && !calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                predicted.check_number(rsp_ch.number);
                results_seen++;
            end
        end
    end

    initial begin : request_side
        int count;
        req_ch.valid       <= 1'b0;
        req_ch.action      <= ACT_DRAW;
        req_ch.seed_low    <= '0;
        req_ch.seed_high   <= '0;
        req_ch.upper_bound <= '0;
        i_rst_n            <= 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The first draw has to run the default seed on its own.
        send_item(ACT_DRAW, 32'h0, 32'h0, 32'h0);
        pace_sender();
        send_item(ACT_BOUNDED, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
        send_item(ACT_BOUNDED, 32'h0, 32'h0, 32'hffff_ffff);
        pace_sender();
        send_item(ACT_BOUNDED, 32'h0, 32'h0, 32'h8000_0000);
        send_item(ACT_BOUNDED, 32'h0, 32'h0, 32'h1);
        send_item(ACT_BOUNDED, 32'h0, 32'h0, 32'h7fff_ffff);
        send_item(ACT_SEED_ONE, 32'h0, 32'hffff_ffff, 32'hffff_ffff);
        send_item(ACT_DRAW, 32'h0, 32'h0, 32'h0);
        pace_sender();
        send_item(ACT_SEED_ONE, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
        send_item(ACT_DRAW, 32'h0, 32'h0, 32'h0);
        send_item(ACT_BOUNDED, 32'h0, 32'h0, 32'h2);
        send_item(ACT_SEED_TWO, 32'h0, 32'h0, 32'h0);
        send_item(ACT_DRAW, 32'h0, 32'h0, 32'h0);
        pace_sender();
        send_item(ACT_SEED_TWO, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_item(ACT_DRAW, 32'h0, 32'h0, 32'h0);
        send_item(ACT_BOUNDED, 32'h0, 32'h0, 32'h5555_5555);
        send_item(ACT_SEED_TWO, 32'h1234_5678, 32'h8765_4321, 32'h0);
        send_item(ACT_BOUNDED, 32'h0, 32'h0, 32'h0);
        send_item(ACT_SEED_ONE, 32'd5489, 32'h0, 32'h0);
        send_item(ACT_DRAW, 32'h0, 32'h0, 32'h0);
        send_item(ACT_DRAW, 32'h0, 32'h0, 32'h0);
        wait_drained();

        // A long run of draws from one seed, so that the state is used up and twisted again.
        send_item(ACT_SEED_ONE, $urandom, $urandom, $urandom);
        count = 0;
        while (predicted.drawn_since_seed < LONG_RUN_WORDS) begin
            if (count % 30 == 0) begin
                idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
            end
            random_item(1'b0);
            count++;
        end
        wait_drained();

        // Mixed seeds and draws; the tail runs at full rate on both sides.
        for (int n = 0; n < 50; n++) begin
            if (n % 15 == 0) begin
                idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
            end
            if (n == 25) begin
                no_idle = 1'b1;
            end
            random_item(1'b1);
        end
        req_ch.valid <= 1'b0;

        while (predicted.expected_numbers.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (predicted.errors == 0 && predicted.expected_numbers.size() == 0) begin
            $display("** mersenne_twister_generator: PASSED **");
        end else begin
            if (predicted.expected_numbers.size() != 0) begin
                $display("%0t: %0d expected numbers never arrived", $time,
                         predicted.expected_numbers.size());
            end
            $display("** mersenne_twister_generator: FAILED **");
        end
        $finish;
    end

endmodule
